FILE: design/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants for the setpoint ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int PRESSURE_BITS = 16;
  localparam int TIME_BITS     = 32;
  localparam int FRAC_BITS     = 8;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Period in ticks with fraction bits; the remainder needs one bit of headroom.
  localparam int PERIOD_BITS   = PRESSURE_BITS + FRAC_BITS;
  localparam int ACC_BITS      = PERIOD_BITS + 1;
  localparam int CNT_BITS      = $clog2(PERIOD_BITS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SERVICE_RATE   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMERGENCY_RATE = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMERG_THRESH   = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEP      = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic [PRESSURE_BITS-1:0] setting;
    logic [TIME_BITS-1:0]     time_now;
  } in_t;

  typedef struct packed {
    logic [PRESSURE_BITS-1:0] pressure;
    logic                     ramping;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_ELAP,
    ST_CHECK,
    ST_MD_PREP,
    ST_MD_SHIFT,
    ST_MD_ADD,
    ST_MD_FIN,
    ST_DONE
  } state_t;

endpackage

FILE: design/srg_sub.sv
// ----------------------------------------------------------------------------
// srg_sub
// Shared compare-and-subtract unit used by the divide and scale sequences.
// ----------------------------------------------------------------------------
module srg_sub (
  input  logic [srg_pkg::ACC_BITS-1:0] x,
  input  logic [srg_pkg::ACC_BITS-1:0] y,
  output logic                         ge,
  output logic [srg_pkg::ACC_BITS-1:0] diff
);

  logic [srg_pkg::ACC_BITS:0] wide;

  // Borrow out of the extended subtract gives the compare for free.
  assign wide = {1'b0, x} - {1'b0, y};
  assign ge   = ~wide[srg_pkg::ACC_BITS];
  assign diff = wide[srg_pkg::ACC_BITS-1:0];

endmodule

FILE: design/setpoint_ramp_generator.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator
// Linear pressure ramp toward a commanded setting, one result per tick.
// ----------------------------------------------------------------------------
// Steps per request: the first tick passes straight to the result, a setting
// change runs a 24-step restoring divide for the period, a tick once a ramp is
// complete only checks the elapsed time, and a tick mid-ramp also runs 16 bits
// of a two-phase multiply-divide. One request at a time: in_stall stays high
// until the result is in the output register. Reset (rst, synchronous) restores
// the register defaults and clears control and ramp state; payload is not reset.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [srg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [srg_pkg::CFG_BITS-1:0]     cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srg_pkg::in_t                     in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output srg_pkg::out_t                    out_data
);

  localparam int P   = srg_pkg::PRESSURE_BITS;
  localparam int T   = srg_pkg::TIME_BITS;
  localparam int F   = srg_pkg::FRAC_BITS;
  localparam int PB  = srg_pkg::PERIOD_BITS;
  localparam int AB  = srg_pkg::ACC_BITS;
  localparam int CB  = srg_pkg::CNT_BITS;

  // Configuration registers
  logic [srg_pkg::CFG_BITS-1:0] service_rate;
  logic [srg_pkg::CFG_BITS-1:0] emergency_rate;
  logic [srg_pkg::CFG_BITS-1:0] emergency_threshold;
  logic [srg_pkg::CFG_BITS-1:0] time_step;

  // Ramp state
  logic          started;
  logic [P-1:0]  last_setting;
  logic [P-1:0]  ramp_origin;
  logic [P-1:0]  present_pressure;
  logic [PB-1:0] ramp_period;
  logic [T-1:0]  change_time;

  // Captured request
  logic [P-1:0]  setting_r;
  logic [T-1:0]  now_r;

  // Sequencer datapath
  srg_pkg::state_t state, state_next;
  logic [AB-1:0] rem;        // running remainder
  logic [PB-1:0] quo;        // quotient shift / count register
  logic [PB-1:0] shf;        // dividend / multiplier bits, MSB first
  logic [PB-1:0] dvs;        // divisor: rate, then period
  logic [PB-1:0] efx;        // elapsed time, fixed point
  logic [PB-1:0] dlt;        // period - efx, for the add phase
  logic [T-1:0]  elapsed;
  logic [CB-1:0] cnt;
  logic          up_dir;
  logic          ramp_flag;

  // Shared unit hookup
  logic [AB-1:0] su_x, su_y, su_diff;
  logic          su_ge;

  srg_sub u_sub (
    .x    (su_x),
    .y    (su_y),
    .ge   (su_ge),
    .diff (su_diff)
  );

  // Helpers for the decide and check steps
  logic [P-1:0]  gap_now;     // |present - setting|
  logic [P-1:0]  rate_sel;
  logic [P-1:0]  gap_ramp;    // |setting - origin|
  logic          ramp_done;
  logic [PB-1:0] efx_now;
  logic          out_free;

  assign gap_now  = (present_pressure > setting_r) ? present_pressure - setting_r
                                                   : setting_r - present_pressure;
  assign rate_sel = (setting_r > emergency_threshold) ? service_rate : emergency_rate;
  assign gap_ramp = (setting_r >= ramp_origin) ? setting_r - ramp_origin
                                               : ramp_origin - setting_r;
  assign efx_now  = {elapsed[P-1:0], {F{1'b0}}};
  // Ramp is still running only if elapsed fits and elapsed<<F is below the period.
  assign ramp_done = !((elapsed <= T'(ramp_period[PB-1:F])) && (efx_now < ramp_period));
  assign out_free  = !out_valid || !out_stall;

  assign in_stall = (state != srg_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      srg_pkg::ST_IDLE: begin
        if (in_valid) state_next = srg_pkg::ST_DECIDE;
      end
      srg_pkg::ST_DECIDE: begin
        if (!started)                       state_next = srg_pkg::ST_DONE;
        else if (setting_r != last_setting) state_next = srg_pkg::ST_DIV;
        else                                state_next = srg_pkg::ST_ELAP;
      end
      srg_pkg::ST_DIV: begin
        if (cnt == '0) state_next = srg_pkg::ST_DONE;
      end
      srg_pkg::ST_ELAP:     state_next = srg_pkg::ST_CHECK;
      srg_pkg::ST_CHECK: begin
        state_next = ramp_done ? srg_pkg::ST_DONE : srg_pkg::ST_MD_PREP;
      end
      srg_pkg::ST_MD_PREP:  state_next = srg_pkg::ST_MD_SHIFT;
      srg_pkg::ST_MD_SHIFT: state_next = srg_pkg::ST_MD_ADD;
      srg_pkg::ST_MD_ADD: begin
        state_next = (cnt == '0) ? srg_pkg::ST_MD_FIN : srg_pkg::ST_MD_SHIFT;
      end
      srg_pkg::ST_MD_FIN:   state_next = srg_pkg::ST_DONE;
      srg_pkg::ST_DONE: begin
        if (out_free) state_next = srg_pkg::ST_IDLE;
      end
      default:              state_next = srg_pkg::ST_IDLE;
    endcase
  end

  // Shared unit operand selection
  always_comb begin
    su_x = '0;
    su_y = '0;
    unique case (state)
      srg_pkg::ST_DIV: begin
        // restoring divide: bring down the next dividend bit
        su_x = {rem[AB-2:0], shf[PB-1]};
        su_y = AB'(dvs);
      end
      srg_pkg::ST_MD_PREP: begin
        su_x = AB'(dvs);
        su_y = AB'(efx);
      end
      srg_pkg::ST_MD_SHIFT: begin
        su_x = {rem[AB-2:0], 1'b0};
        su_y = AB'(dvs);
      end
      srg_pkg::ST_MD_ADD: begin
        // rem + efx >= period  <=>  rem >= period - efx
        su_x = rem;
        su_y = AB'(dlt);
      end
      default: begin
        su_x = '0;
        su_y = '0;
      end
    endcase
  end

  // State register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == srg_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      service_rate        <= srg_pkg::CFG_BITS'(100);
      emergency_rate      <= srg_pkg::CFG_BITS'(1000);
      emergency_threshold <= srg_pkg::CFG_BITS'(5000);
      time_step           <= srg_pkg::CFG_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        srg_pkg::CFG_SERVICE_RATE:   service_rate        <= cfg_data;
        srg_pkg::CFG_EMERGENCY_RATE: emergency_rate      <= cfg_data;
        srg_pkg::CFG_EMERG_THRESH:   emergency_threshold <= cfg_data;
        srg_pkg::CFG_TIME_STEP:      time_step           <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      last_setting     <= '0;
      ramp_origin      <= '0;
      present_pressure <= '0;
      ramp_period      <= '0;
      change_time      <= '0;
    end else begin
      unique case (state)
        srg_pkg::ST_DECIDE: begin
          if (!started) begin
            started          <= 1'b1;
            last_setting     <= setting_r;
            present_pressure <= setting_r;
          end else if (setting_r != last_setting) begin
            change_time  <= now_r;
            last_setting <= setting_r;
            ramp_origin  <= present_pressure;
          end
        end
        srg_pkg::ST_DIV: begin
          if (cnt == '0) ramp_period <= {quo[PB-2:0], su_ge};
        end
        srg_pkg::ST_CHECK: begin
          if (ramp_done) present_pressure <= setting_r;
        end
        srg_pkg::ST_MD_FIN: begin
          present_pressure <= up_dir ? ramp_origin + quo[P-1:0]
                                     : ramp_origin - quo[P-1:0];
        end
        default: ;
      endcase
    end
  end

  // Sequencer datapath (payload, no reset)
  always_ff @(posedge clk) begin
    if (state == srg_pkg::ST_IDLE && in_valid) begin
      setting_r <= in_data.setting;
      now_r     <= in_data.time_now;
    end
    unique case (state)
      srg_pkg::ST_DECIDE: begin
        // flag set here only on a setting change that leaves a gap to close; MD_FIN sets it mid-ramp
        ramp_flag <= started && (setting_r != last_setting)
                     && (present_pressure != setting_r);
        elapsed   <= now_r + T'(time_step);
        rem       <= '0;
        quo       <= '0;
        shf       <= {gap_now, {F{1'b0}}};
        dvs       <= PB'((rate_sel == '0) ? P'(1) : rate_sel);
        cnt       <= CB'(PB - 1);
      end
      srg_pkg::ST_DIV: begin
        rem <= su_ge ? su_diff : su_x;
        quo <= {quo[PB-2:0], su_ge};
        shf <= {shf[PB-2:0], 1'b0};
        cnt <= cnt - CB'(1);
      end
      srg_pkg::ST_ELAP: begin
        elapsed <= elapsed - change_time;
      end
      srg_pkg::ST_CHECK: begin
        efx    <= efx_now;
        dvs    <= ramp_period;
        shf    <= {gap_ramp, {F{1'b0}}};
        up_dir <= (setting_r >= ramp_origin);
        rem    <= '0;
        quo    <= '0;
        cnt    <= CB'(P - 1);
      end
      srg_pkg::ST_MD_PREP: begin
        dlt <= su_diff[PB-1:0];
      end
      srg_pkg::ST_MD_SHIFT: begin
        rem <= su_ge ? su_diff : su_x;
        quo <= {quo[PB-2:0], su_ge};
      end
      srg_pkg::ST_MD_ADD: begin
        if (shf[PB-1]) begin
          rem <= su_ge ? su_diff : rem + AB'(efx);
          if (su_ge) quo <= quo + PB'(1);
        end
        shf <= {shf[PB-2:0], 1'b0};
        cnt <= cnt - CB'(1);
      end
      srg_pkg::ST_MD_FIN: begin
        ramp_flag <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == srg_pkg::ST_DONE && out_free) begin
      out_data.pressure <= present_pressure;
      out_data.ramping  <= ramp_flag;
    end
  end

endmodule

FILE: tb/setpoint_ramp_generator_tb.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_tb
// Self-checking bench for the setpoint ramp generator. Ticks go in over the
// valid/stall request channel. A cycle-free predictor works out the relay
// pressure and ramp flag for each accepted request. Results are checked in
// order as they leave the block. Directed corner ticks come first, then
// random ramp sequences under several register settings, with random idling
// on both channels outside one steady-flow stretch.
// ----------------------------------------------------------------------------
module setpoint_ramp_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             cfg_we    = 1'b0;
  logic [srg_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [srg_pkg::CFG_BITS-1:0]     cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  srg_pkg::in_t                     in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  srg_pkg::out_t                    out_data;

  setpoint_ramp_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Percentage of cycles in which the sender holds off and the receiver
  // stalls; dropped to zero for the steady-flow stretch.
  int idle_pct   = 15;
  int fail_count = 0;

  // Relay outputs still owed by the block, oldest first.
  srg_pkg::out_t pending_relay[$];

  // Running tick time used by the random sequences.
  logic [srg_pkg::TIME_BITS-1:0] tick_now = '0;

  // Predictor's copy of the registers, at their reset values.
  logic [srg_pkg::CFG_BITS-1:0] svc_rate   = 16'd100;
  logic [srg_pkg::CFG_BITS-1:0] emg_rate   = 16'd1000;
  logic [srg_pkg::CFG_BITS-1:0] emg_thresh = 16'd5000;
  logic [srg_pkg::CFG_BITS-1:0] step_ticks = 16'd1;

  // Predictor's copy of the ramp state.
  logic                              seen_first   = 1'b0;
  logic [srg_pkg::PRESSURE_BITS-1:0] held_setting = '0;
  logic [srg_pkg::PRESSURE_BITS-1:0] origin_p     = '0;
  logic [srg_pkg::PRESSURE_BITS-1:0] relay_p      = '0;
  logic [srg_pkg::PERIOD_BITS-1:0]   period_fx    = '0;
  logic [srg_pkg::TIME_BITS-1:0]     ramp_t0      = '0;

  // Advance the ramp state by one tick and return the relay output it gives.
  function automatic srg_pkg::out_t predict_relay(input srg_pkg::in_t req);
    logic [srg_pkg::PRESSURE_BITS-1:0] gap;
    logic [srg_pkg::CFG_BITS-1:0]      rate;
    logic [srg_pkg::TIME_BITS-1:0]     elapsed;
    logic [63:0]                       efx;
    logic [63:0]                       step;
    logic                              done;
    srg_pkg::out_t                     res;
    res.ramping = 1'b0;
    if (!seen_first) begin
      // first tick after reset: pass straight through, period left alone
      seen_first   = 1'b1;
      held_setting = req.setting;
      relay_p      = req.setting;
    end else if (req.setting != held_setting) begin
      // new setting: latch the ramp and hold the output for this tick
      gap  = (relay_p > req.setting) ? relay_p - req.setting : req.setting - relay_p;
      rate = (req.setting > emg_thresh) ? svc_rate : emg_rate;
      if (rate == '0) rate = 16'd1;
      period_fx    = srg_pkg::PERIOD_BITS'({gap, 8'h00} / rate);
      ramp_t0      = req.time_now;
      held_setting = req.setting;
      origin_p     = relay_p;
      res.ramping  = (relay_p != req.setting);
    end else begin
      // elapsed time wraps, so time running backwards reads as complete
      elapsed = req.time_now + srg_pkg::TIME_BITS'(step_ticks) - ramp_t0;
      done    = 1'b1;
      efx     = '0;
      if (elapsed <= (period_fx >> srg_pkg::FRAC_BITS)) begin
        efx = 64'(elapsed) << srg_pkg::FRAC_BITS;
        if (efx < 64'(period_fx)) done = 1'b0;
      end
      if (done) begin
        relay_p = req.setting;
      end else begin
        if (req.setting >= origin_p) begin
          step    = 64'(req.setting - origin_p) * efx / 64'(period_fx);
          relay_p = origin_p + step[srg_pkg::PRESSURE_BITS-1:0];
        end else begin
          step    = 64'(origin_p - req.setting) * efx / 64'(period_fx);
          relay_p = origin_p - step[srg_pkg::PRESSURE_BITS-1:0];
        end
        res.ramping = 1'b1;
      end
    end
    res.pressure = relay_p;
    return res;
  endfunction

  // Result side: random stall, and every accepted result checked against
  // the oldest outstanding prediction.
  always @(posedge clk) begin
    srg_pkg::out_t want;
    out_stall <= ($urandom_range(99) < idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_relay.size() == 0) begin
        $error("result with no request pending: pressure %0d ramping %0d",
               out_data.pressure, out_data.ramping);
        fail_count++;
      end else begin
        want = pending_relay.pop_front();
        if (out_data.pressure !== want.pressure) begin
          $error("pressure: expected %0d, got %0d", want.pressure, out_data.pressure);
          fail_count++;
        end
        if (out_data.ramping !== want.ramping) begin
          $error("ramping: expected %0d, got %0d", want.ramping, out_data.ramping);
          fail_count++;
        end
      end
    end
  end

  // Offer one request, idling first at random, and log its prediction once
  // the block takes it. Valid stays high afterwards so back-to-back requests
  // need no extra edge; drain_requests lowers it.
  task automatic send_tick(input logic [srg_pkg::PRESSURE_BITS-1:0] setting,
                           input logic [srg_pkg::TIME_BITS-1:0] now);
    srg_pkg::in_t req;
    req.setting  = setting;
    req.time_now = now;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_relay = {pending_relay, predict_relay(req)};
  endtask

  // Stop offering requests and wait for every owed result.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_relay.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srg_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [srg_pkg::CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      srg_pkg::CFG_SERVICE_RATE:   svc_rate   = val;
      srg_pkg::CFG_EMERGENCY_RATE: emg_rate   = val;
      srg_pkg::CFG_EMERG_THRESH:   emg_thresh = val;
      srg_pkg::CFG_TIME_STEP:      step_ticks = val;
      default: ;
    endcase
  endtask

  // Only called with the block idle.
  task automatic apply_config(input logic [srg_pkg::CFG_BITS-1:0] svc, emg, thr, stp);
    write_reg(srg_pkg::CFG_SERVICE_RATE, svc);
    write_reg(srg_pkg::CFG_EMERGENCY_RATE, emg);
    write_reg(srg_pkg::CFG_EMERG_THRESH, thr);
    write_reg(srg_pkg::CFG_TIME_STEP, stp);
    cfg_we <= 1'b0;
  endtask

  // Random ramps: mostly a setting change followed by a run of ticks at that
  // setting with time moving on by varied amounts; the rest is noise with an
  // unrelated setting and time.
  task automatic run_ramps(input int n_req);
    int                                sent;
    int                                hold;
    int                                dice;
    logic [srg_pkg::PRESSURE_BITS-1:0] target;
    sent   = 0;
    target = held_setting;
    while (sent < n_req) begin
      if ($urandom_range(99) < 20) begin
        target   = srg_pkg::PRESSURE_BITS'($urandom());
        tick_now = $urandom();
        send_tick(target, tick_now);
        sent++;
      end else begin
        if ($urandom_range(1) == 1) target = srg_pkg::PRESSURE_BITS'($urandom());
        else target = target + srg_pkg::PRESSURE_BITS'($urandom_range(2000)) - 16'd1000;
        send_tick(target, tick_now);
        sent++;
        hold = $urandom_range(1, 30);
        if (hold > n_req - sent) hold = n_req - sent;
        repeat (hold) begin
          dice = $urandom_range(99);
          if (dice < 70)      tick_now += $urandom_range(8);
          else if (dice < 88) tick_now += $urandom_range(400);
          else if (dice < 95) tick_now += $urandom_range(5000);
          else if (dice < 98) tick_now -= $urandom_range(1, 50);
          else                tick_now  = $urandom();
          send_tick(target, tick_now);
          sent++;
        end
      end
    end
    drain_requests();
  endtask

  // First tick after reset passes the setting through; a repeat tick with
  // a zero period stays put.
  task automatic test_first_tick();
    send_tick(16'd3000, 32'd100);
    send_tick(16'd3000, 32'd101);
    drain_requests();
  endtask

  // Corner ticks under the reset register values.
  task automatic test_special_cases();
    // full-scale rise on the service rate, then run to completion
    send_tick(16'hFFFF, 32'd200);
    send_tick(16'hFFFF, 32'd200);
    send_tick(16'hFFFF, 32'd500);
    send_tick(16'hFFFF, 32'd825);
    // full-scale fall on the emergency rate
    send_tick(16'h0000, 32'd1000);
    send_tick(16'h0000, 32'd1001);
    send_tick(16'h0000, 32'd1030);
    send_tick(16'h0000, 32'd1065);
    // one-step change truncates to a zero period
    send_tick(16'd1, 32'd2000);
    send_tick(16'd1, 32'd2001);
    // change away and straight back: held pressure already at the setting
    send_tick(16'd500, 32'd3000);
    send_tick(16'd1, 32'd3001);
    send_tick(16'd1, 32'd3002);
    // ramp across the time wrap
    send_tick(16'd40000, 32'hFFFF_FFF0);
    send_tick(16'd40000, 32'hFFFF_FFFF);
    send_tick(16'd40000, 32'h0000_0005);
    send_tick(16'd40000, 32'h0000_0100);
    // time jumps back: huge elapsed, ramp counts as complete
    send_tick(16'd40000, 32'hFFFF_FF00);
    // zero elapsed time mid-ramp, then backwards
    send_tick(16'd39000, 32'd10);
    send_tick(16'd39000, 32'd9);
    send_tick(16'd39000, 32'd5);
    drain_requests();
    tick_now = 32'd5000;
  endtask

  // Each register at both ends of its range, zero rates among them.
  task automatic test_register_extremes();
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_ramps(30);
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_ramps(30);
    apply_config(16'd1, 16'd2, 16'h0000, 16'hFFFF);
    run_ramps(30);
    apply_config(16'd500, 16'd3, 16'hFFFF, 16'h0000);
    run_ramps(30);
    apply_config(srg_pkg::CFG_BITS'($urandom()), srg_pkg::CFG_BITS'($urandom()),
                 srg_pkg::CFG_BITS'($urandom()), srg_pkg::CFG_BITS'($urandom_range(4)));
    run_ramps(30);
    apply_config(16'd100, 16'd1000, 16'd5000, 16'd1);
    run_ramps(30);
  endtask

  // Long stretch with no idling on either side.
  task automatic test_steady_flow();
    idle_pct = 0;
    run_ramps(120);
    idle_pct = 15;
  endtask

  // Sender repeatedly stops until every result is back before resuming.
  task automatic test_pause_until_drained();
    apply_config(16'd250, 16'd2000, srg_pkg::CFG_BITS'($urandom()), 16'd2);
    repeat (4) run_ramps(25);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_first_tick();
    test_special_cases();
    test_register_extremes();
    test_steady_flow();
    test_pause_until_drained();
    // catch any stray result after the last one owed
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("setpoint_ramp_generator_tb passed");
    else $display("setpoint_ramp_generator_tb failed");
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("setpoint_ramp_generator_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
design/srg_pkg.sv
design/srg_sub.sv
design/setpoint_ramp_generator.sv
tb/setpoint_ramp_generator_tb.sv
